@@ design/kbc8042_pkg.sv @@
// Shared types and codes for the 8042-style keyboard controller.
package kbc8042_pkg;

  // Bus command codes carried by a request.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Register offsets on the host bus.
  localparam logic [2:0] PORT_DATA    = 3'd0;
  localparam logic [2:0] PORT_SPEAKER = 3'd1;
  localparam logic [2:0] PORT_TIMER   = 3'd2;
  localparam logic [2:0] PORT_STATUS  = 3'd4;

  // Controller kinds.
  localparam logic [1:0] KIND_AT    = 2'd0;
  localparam logic [1:0] KIND_AT386 = 2'd1;
  localparam logic [1:0] KIND_PS2   = 2'd2;

  // Controller commands written to the status/command port.
  localparam logic [7:0] CC_IF_TEST     = 8'ha9;
  localparam logic [7:0] CC_SELF_TEST   = 8'haa;
  localparam logic [7:0] CC_KBD_TEST    = 8'hab;
  localparam logic [7:0] CC_KBD_DISABLE = 8'had;
  localparam logic [7:0] CC_KBD_ENABLE  = 8'hae;
  localparam logic [7:0] CC_READ_INPUT  = 8'hc0;
  localparam logic [7:0] CC_STATUS_LOW  = 8'hc1;
  localparam logic [7:0] CC_STATUS_HIGH = 8'hc2;
  localparam logic [7:0] CC_READ_OUTPUT = 8'hd0;
  localparam logic [7:0] CC_WRITE_OUTPUT = 8'hd1;
  localparam logic [7:0] CC_WRITE_KBD_BUF = 8'hd2;
  localparam logic [7:0] CC_WRITE_AUX_BUF = 8'hd3;
  localparam logic [7:0] CC_WRITE_AUX     = 8'hd4;
  localparam logic [3:0] CC_PULSE_HIGH    = 4'hf;

  // Write stages armed by the staged-write commands.
  localparam logic [2:0] STAGE_IDLE     = 3'd0;
  localparam logic [2:0] STAGE_OUTPUT   = 3'd1;
  localparam logic [2:0] STAGE_KBD_BUF  = 3'd2;
  localparam logic [2:0] STAGE_AUX_BUF  = 3'd3;
  localparam logic [2:0] STAGE_AUX      = 3'd4;

  // Status read modes.
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_LOW    = 2'd1;
  localparam logic [1:0] MODE_HIGH   = 2'd2;

  // Fixed values.
  localparam logic [7:0] SELF_TEST_OK     = 8'h55;
  localparam logic [7:0] INPUT_PORT_RESET = 8'ha0;
  localparam logic [3:0] TOGGLE_RESET     = 4'd10;
  localparam logic [3:0] TOGGLE_AT        = 4'd4;
  localparam logic [3:0] TOGGLE_PS2       = 4'd8;

  // Configuration register indexes.
  localparam logic REG_KIND       = 1'b0;
  localparam logic REG_INPUT_PORT = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] port;
    logic [7:0] write_data;
    logic       kbd_byte_valid;
    logic [7:0] kbd_byte;
    logic       irq_pending;
    logic       timer_two_out;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       kbd_byte_taken;
    logic       irq_raise;
    logic       kbd_send_valid;
    logic [7:0] kbd_send_byte;
    logic       speaker_update;
    logic [1:0] speaker_bits;
    logic       a20_update;
    logic       a20_enable;
    logic       cpu_reset_pulse;
  } rsp_t;

  typedef struct packed {
    logic [1:0] controller_kind;
    logic [7:0] input_port_value;
  } cfg_t;

endpackage

@@ design/keyboard_controller_8042.sv @@
// Top level of the 8042-style keyboard controller: request and response stages, config port.
// A request passes through the request register and then the response register.
// Throughput: one request per cycle; the request and response registers decouple the two sides.
// The only stall comes from a held response backing up through the request register.
// Reset is synchronous and active high; it restores all controller state and the
// configuration registers at once, with no clearing pass.
module keyboard_controller_8042 (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_stall,
  input  kbc8042_pkg::req_t  req_data,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output kbc8042_pkg::rsp_t  rsp_data
);

  kbc8042_pkg::cfg_t cfg;
  kbc8042_pkg::req_t s1_req;
  kbc8042_pkg::rsp_t step_rsp;
  logic              s1_valid;
  logic              advance;
  logic              cfg_write;

  // Configuration port: always ready, registers decoded by word address.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.controller_kind  <= kbc8042_pkg::KIND_AT;
      cfg.input_port_value <= kbc8042_pkg::INPUT_PORT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == kbc8042_pkg::REG_KIND) begin
        cfg.controller_kind <= pwdata[1:0];
      end else begin
        cfg.input_port_value <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == kbc8042_pkg::REG_KIND) ? {30'd0, cfg.controller_kind}
                                                      : {24'd0, cfg.input_port_value};

  // The request stage moves on unless a response is held.
  assign req_stall = s1_valid && rsp_valid && rsp_stall;
  assign advance   = s1_valid && !(rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      s1_req <= req_data;
    end
  end

  kbc8042_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .req  (s1_req),
    .cfg  (cfg),
    .rsp  (step_rsp)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= step_rsp;
    end
  end

  // A request is only held back when a response is waiting downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (rsp_valid && rsp_stall))
    else $error("request stalled without a held response");

  // A request that leaves the request stage shows up as a response next cycle.
  a_advance_rsp: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("advanced request produced no response");

  // A processor reset pulse always comes with full addressing.
  a_reset_a20: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.cpu_reset_pulse) |-> (rsp_data.a20_update && rsp_data.a20_enable))
    else $error("reset pulse without address mask update");

endmodule

@@ design/kbc8042_engine.sv @@
// Controller state and the single-pass decode of one bus request.
module kbc8042_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  kbc8042_pkg::req_t   req,
  input  kbc8042_pkg::cfg_t   cfg,
  output kbc8042_pkg::rsp_t   rsp
);

  logic [7:0] data_buffer,      data_buffer_next;
  logic [7:0] output_port,      output_port_next;
  logic       buffer_full,      buffer_full_next;
  logic       keyboard_enabled, keyboard_enabled_next;
  logic       sending_flag,     sending_flag_next;
  logic [2:0] write_stage,      write_stage_next;
  logic [1:0] status_mode,      status_mode_next;
  logic [7:0] speaker_byte,     speaker_byte_next;
  logic [3:0] toggle_countdown, toggle_countdown_next;
  logic       refresh_toggle,   refresh_toggle_next;

  // Decode the request against the current state.
  always_comb begin
    data_buffer_next      = data_buffer;
    output_port_next      = output_port;
    buffer_full_next      = buffer_full;
    keyboard_enabled_next = keyboard_enabled;
    sending_flag_next     = sending_flag;
    write_stage_next      = write_stage;
    status_mode_next      = status_mode;
    speaker_byte_next     = speaker_byte;
    toggle_countdown_next = toggle_countdown;
    refresh_toggle_next   = refresh_toggle;
    rsp = '0;

    case (req.command)
      kbc8042_pkg::CMD_TICK: begin
        // Poll the keyboard side for a new byte.
        if (!req.irq_pending && keyboard_enabled && !buffer_full && req.kbd_byte_valid) begin
          rsp.kbd_byte_taken = 1'b1;
          data_buffer_next   = req.kbd_byte;
          buffer_full_next   = 1'b1;
          rsp.irq_raise      = 1'b1;
        end
      end
      kbc8042_pkg::CMD_READ: begin
        case (req.port)
          kbc8042_pkg::PORT_DATA: begin
            rsp.read_data = data_buffer;
            if (cfg.controller_kind != kbc8042_pkg::KIND_AT386) begin
              buffer_full_next = 1'b0;
            end
          end
          kbc8042_pkg::PORT_SPEAKER: begin
            // Reading the speaker port also advances the refresh toggle.
            buffer_full_next = 1'b0;
            if (toggle_countdown == 4'd0) begin
              toggle_countdown_next = (cfg.controller_kind == kbc8042_pkg::KIND_PS2) ?
                                      kbc8042_pkg::TOGGLE_PS2 : kbc8042_pkg::TOGGLE_AT;
              refresh_toggle_next = ~refresh_toggle;
            end else begin
              toggle_countdown_next = toggle_countdown - 4'd1;
            end
            rsp.read_data = {2'b00, speaker_byte[0], refresh_toggle_next,
                             speaker_byte[3:0]};
          end
          kbc8042_pkg::PORT_TIMER: begin
            rsp.read_data = {2'b00, req.timer_two_out, 5'b00000};
          end
          kbc8042_pkg::PORT_STATUS: begin
            // A status read may pull in a waiting keyboard byte first.
            if (!buffer_full && req.kbd_byte_valid) begin
              rsp.kbd_byte_taken = 1'b1;
              data_buffer_next   = req.kbd_byte;
              buffer_full_next   = 1'b1;
              rsp.irq_raise      = !req.irq_pending;
            end
            rsp.read_data[0] = buffer_full_next;
            rsp.read_data[1] = sending_flag;
            rsp.read_data[2] = 1'b1;
            sending_flag_next = 1'b0;
            case (status_mode)
              kbc8042_pkg::MODE_NORMAL: rsp.read_data[4] = !keyboard_enabled;
              kbc8042_pkg::MODE_LOW: begin
                rsp.read_data[3:0] = rsp.read_data[3:0] | cfg.input_port_value[3:0];
              end
              kbc8042_pkg::MODE_HIGH: begin
                rsp.read_data[7:4] = rsp.read_data[7:4] | cfg.input_port_value[3:0];
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      kbc8042_pkg::CMD_WRITE: begin
        case (req.port)
          kbc8042_pkg::PORT_DATA: begin
            status_mode_next = kbc8042_pkg::MODE_NORMAL;
            write_stage_next = kbc8042_pkg::STAGE_IDLE;
            case (write_stage)
              kbc8042_pkg::STAGE_OUTPUT: begin
                output_port_next = req.write_data;
                rsp.a20_update   = 1'b1;
                rsp.a20_enable   = req.write_data[1];
              end
              kbc8042_pkg::STAGE_AUX_BUF, kbc8042_pkg::STAGE_AUX: begin
                data_buffer_next = req.write_data;
              end
              default: begin
                // Idle or keyboard-buffer stage: the byte goes to the keyboard.
                data_buffer_next  = req.write_data;
                sending_flag_next = 1'b1;
                rsp.kbd_send_valid = 1'b1;
                rsp.kbd_send_byte  = req.write_data;
              end
            endcase
          end
          kbc8042_pkg::PORT_SPEAKER: begin
            speaker_byte_next  = req.write_data;
            rsp.speaker_update = 1'b1;
            rsp.speaker_bits   = req.write_data[1:0];
          end
          kbc8042_pkg::PORT_STATUS: begin
            // Controller command.
            case (req.write_data)
              kbc8042_pkg::CC_IF_TEST, kbc8042_pkg::CC_KBD_TEST: begin
                data_buffer_next = 8'h00;
                buffer_full_next = 1'b1;
                rsp.irq_raise    = !req.irq_pending;
              end
              kbc8042_pkg::CC_SELF_TEST: begin
                data_buffer_next = kbc8042_pkg::SELF_TEST_OK;
                buffer_full_next = 1'b1;
                rsp.irq_raise    = !req.irq_pending;
              end
              kbc8042_pkg::CC_KBD_DISABLE: keyboard_enabled_next = 1'b0;
              kbc8042_pkg::CC_KBD_ENABLE:  keyboard_enabled_next = 1'b1;
              kbc8042_pkg::CC_READ_INPUT: begin
                data_buffer_next = cfg.input_port_value;
                buffer_full_next = 1'b1;
                rsp.irq_raise    = !req.irq_pending;
              end
              kbc8042_pkg::CC_STATUS_LOW:  status_mode_next = kbc8042_pkg::MODE_LOW;
              kbc8042_pkg::CC_STATUS_HIGH: status_mode_next = kbc8042_pkg::MODE_HIGH;
              kbc8042_pkg::CC_READ_OUTPUT: begin
                data_buffer_next = output_port;
                buffer_full_next = 1'b1;
                rsp.irq_raise    = !req.irq_pending;
              end
              kbc8042_pkg::CC_WRITE_OUTPUT:  write_stage_next = kbc8042_pkg::STAGE_OUTPUT;
              kbc8042_pkg::CC_WRITE_KBD_BUF: write_stage_next = kbc8042_pkg::STAGE_KBD_BUF;
              kbc8042_pkg::CC_WRITE_AUX_BUF: write_stage_next = kbc8042_pkg::STAGE_AUX_BUF;
              kbc8042_pkg::CC_WRITE_AUX:     write_stage_next = kbc8042_pkg::STAGE_AUX;
              default: begin
                // Even codes in the top row pulse the processor reset.
                if (req.write_data[7:4] == kbc8042_pkg::CC_PULSE_HIGH &&
                    !req.write_data[0]) begin
                  rsp.cpu_reset_pulse = 1'b1;
                  rsp.a20_update      = 1'b1;
                  rsp.a20_enable      = 1'b1;
                end
              end
            endcase
            sending_flag_next = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Controller state, updated once per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_buffer      <= 8'h00;
      output_port      <= 8'h00;
      buffer_full      <= 1'b0;
      keyboard_enabled <= 1'b0;
      sending_flag     <= 1'b0;
      write_stage      <= kbc8042_pkg::STAGE_IDLE;
      status_mode      <= kbc8042_pkg::MODE_NORMAL;
      speaker_byte     <= 8'h00;
      toggle_countdown <= kbc8042_pkg::TOGGLE_RESET;
      refresh_toggle   <= 1'b0;
    end else if (fire) begin
      data_buffer      <= data_buffer_next;
      output_port      <= output_port_next;
      buffer_full      <= buffer_full_next;
      keyboard_enabled <= keyboard_enabled_next;
      sending_flag     <= sending_flag_next;
      write_stage      <= write_stage_next;
      status_mode      <= status_mode_next;
      speaker_byte     <= speaker_byte_next;
      toggle_countdown <= toggle_countdown_next;
      refresh_toggle   <= refresh_toggle_next;
    end
  end

endmodule

@@ tb/keyboard_controller_8042_tb.sv @@
// Self-checking testbench for the 8042-style keyboard controller: directed table, then random traffic.
module keyboard_controller_8042_tb;
  import kbc8042_pkg::*;

  // Codes that the package leaves unnamed but the fields still allow.
  localparam logic [1:0] CMD_SPARE  = 2'd3;
  localparam logic [2:0] PORT_SPARE = 3'd3;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 50;

  // One request to send, with an optional expectation typed in by hand.
  typedef struct {
    req_t rq;
    logic typed;
    rsp_t typed_rsp;
  } stim_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid;
  logic        req_stall;
  req_t        req_data;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp_data;

  keyboard_controller_8042 u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  // Controller copy kept by the testbench.
  logic [1:0] cfg_kind;
  logic [7:0] cfg_inport;
  logic [7:0] kb_data;
  logic [7:0] kb_outport;
  logic       kb_full;
  logic       kb_enabled;
  logic       kb_cmd_flag;
  logic [2:0] kb_stage;
  logic [1:0] kb_status_mode;
  logic [7:0] kb_speaker;
  logic [3:0] kb_refresh_count;
  logic       kb_refresh_bit;

  stim_t host_requests[$];
  rsp_t  expected_rsps[$];
  rsp_t  chk_want;

  int    n_fail;
  int    n_sent_reqs;
  int    n_checked;
  int    n_taken;
  int    n_to_kbd;
  int    n_pulses;
  int    n_settings;
  bit    no_idle;
  bit    long_hold;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case the handshakes lock up.
  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

  function automatic rsp_t make_rsp(logic [7:0] rd, logic taken, logic irq, logic send_v,
                                    logic [7:0] send_b, logic spk_u, logic [1:0] spk_b,
                                    logic a20_u, logic a20_e, logic cpu_rst);
    rsp_t o;
    o.read_data       = rd;
    o.kbd_byte_taken  = taken;
    o.irq_raise       = irq;
    o.kbd_send_valid  = send_v;
    o.kbd_send_byte   = send_b;
    o.speaker_update  = spk_u;
    o.speaker_bits    = spk_b;
    o.a20_update      = a20_u;
    o.a20_enable      = a20_e;
    o.cpu_reset_pulse = cpu_rst;
    return o;
  endfunction

  function automatic stim_t row(logic [1:0] cmd, logic [2:0] port, logic [7:0] wd, logic kv,
                                logic [7:0] kb, logic pend, logic t2, logic typed, rsp_t rs);
    stim_t s;
    s.rq.command        = cmd;
    s.rq.port           = port;
    s.rq.write_data     = wd;
    s.rq.kbd_byte_valid = kv;
    s.rq.kbd_byte       = kb;
    s.rq.irq_pending    = pend;
    s.rq.timer_two_out  = t2;
    s.typed             = typed;
    s.typed_rsp         = rs;
    return s;
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.command        = 2'($urandom_range(0, 3));
    r.port           = 3'($urandom_range(0, 7));
    r.write_data     = 8'($urandom_range(0, 255));
    r.kbd_byte_valid = 1'($urandom_range(0, 1));
    r.kbd_byte       = 8'($urandom_range(0, 255));
    r.irq_pending    = 1'($urandom_range(0, 1));
    r.timer_two_out  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Controller command byte, weighted so the keyboard is enabled most of the time.
  function automatic logic [7:0] random_ctrl_cmd();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = CC_KBD_ENABLE;
      3:       c = CC_KBD_DISABLE;
      4:       c = ($urandom_range(0, 2) == 0) ? CC_IF_TEST :
                   ($urandom_range(0, 1) == 0) ? CC_SELF_TEST : CC_KBD_TEST;
      5:       c = ($urandom_range(0, 1) == 0) ? CC_STATUS_LOW : CC_STATUS_HIGH;
      6:       c = ($urandom_range(0, 1) == 0) ? CC_READ_OUTPUT : CC_READ_INPUT;
      7:       c = {CC_PULSE_HIGH, 3'($urandom_range(0, 7)), 1'b0};
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // A byte lands in the data buffer and raises the interrupt unless one is pending.
  task automatic load_host_byte(input logic [7:0] b, input logic pend, inout rsp_t o);
    kb_data = b;
    kb_full = 1'b1;
    if (!pend) begin
      o.irq_raise = 1'b1;
    end
  endtask

  task automatic send_kbd_byte(input logic [7:0] b, inout rsp_t o);
    kb_data          = b;
    kb_cmd_flag      = 1'b1;
    o.kbd_send_valid = 1'b1;
    o.kbd_send_byte  = b;
  endtask

  // Works out the response to one request and advances the controller copy.
  task automatic predict_kbc_response(input req_t r, output rsp_t o);
    logic [7:0] rd;
    o  = '0;
    rd = 8'h00;
    case (r.command)
      CMD_TICK: begin
        if (!r.irq_pending && kb_enabled && !kb_full && r.kbd_byte_valid) begin
          o.kbd_byte_taken = 1'b1;
          load_host_byte(r.kbd_byte, r.irq_pending, o);
        end
      end
      CMD_READ: begin
        case (r.port)
          PORT_DATA: begin
            rd = kb_data;
            if (cfg_kind != KIND_AT386) begin
              kb_full = 1'b0;
            end
          end
          PORT_SPEAKER: begin
            kb_full = 1'b0;
            if (kb_refresh_count == 4'd0) begin
              kb_refresh_count = (cfg_kind == KIND_PS2) ? TOGGLE_PS2 : TOGGLE_AT;
              kb_refresh_bit   = ~kb_refresh_bit;
            end else begin
              kb_refresh_count = kb_refresh_count - 4'd1;
            end
            rd = {2'b00, kb_speaker[0], kb_refresh_bit, kb_speaker[3:0]};
          end
          PORT_TIMER: begin
            rd = r.timer_two_out ? 8'h20 : 8'h00;
          end
          PORT_STATUS: begin
            if (!kb_full && r.kbd_byte_valid) begin
              o.kbd_byte_taken = 1'b1;
              load_host_byte(r.kbd_byte, r.irq_pending, o);
            end
            rd[0]       = kb_full;
            rd[1]       = kb_cmd_flag;
            rd[2]       = 1'b1;
            kb_cmd_flag = 1'b0;
            case (kb_status_mode)
              MODE_NORMAL: rd[4] = ~kb_enabled;
              MODE_LOW:    rd = rd | {4'h0, cfg_inport[3:0]};
              MODE_HIGH:   rd = rd | {cfg_inport[3:0], 4'h0};
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      CMD_WRITE: begin
        case (r.port)
          PORT_DATA: begin
            kb_status_mode = MODE_NORMAL;
            case (kb_stage)
              STAGE_OUTPUT: begin
                kb_outport   = r.write_data;
                o.a20_update = 1'b1;
                o.a20_enable = r.write_data[1];
              end
              STAGE_AUX_BUF, STAGE_AUX: kb_data = r.write_data;
              default: send_kbd_byte(r.write_data, o);
            endcase
            kb_stage = STAGE_IDLE;
          end
          PORT_SPEAKER: begin
            kb_speaker       = r.write_data;
            o.speaker_update = 1'b1;
            o.speaker_bits   = r.write_data[1:0];
          end
          PORT_STATUS: begin
            case (r.write_data)
              CC_IF_TEST, CC_KBD_TEST: load_host_byte(8'h00, r.irq_pending, o);
              CC_SELF_TEST:    load_host_byte(SELF_TEST_OK, r.irq_pending, o);
              CC_KBD_DISABLE:  kb_enabled = 1'b0;
              CC_KBD_ENABLE:   kb_enabled = 1'b1;
              CC_READ_INPUT:   load_host_byte(cfg_inport, r.irq_pending, o);
              CC_STATUS_LOW:   kb_status_mode = MODE_LOW;
              CC_STATUS_HIGH:  kb_status_mode = MODE_HIGH;
              CC_READ_OUTPUT:  load_host_byte(kb_outport, r.irq_pending, o);
              CC_WRITE_OUTPUT: kb_stage = STAGE_OUTPUT;
              CC_WRITE_KBD_BUF: kb_stage = STAGE_KBD_BUF;
              CC_WRITE_AUX_BUF: kb_stage = STAGE_AUX_BUF;
              CC_WRITE_AUX:    kb_stage = STAGE_AUX;
              default: begin
                // Even commands in the top range pulse the output port lines.
                if (r.write_data[7:4] == CC_PULSE_HIGH && !r.write_data[0]) begin
                  o.cpu_reset_pulse = 1'b1;
                  o.a20_update      = 1'b1;
                  o.a20_enable      = 1'b1;
                end
              end
            endcase
            kb_cmd_flag = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    o.read_data = rd;
  endtask

  task automatic queue_req(input req_t r);
    stim_t s;
    s.rq        = r;
    s.typed     = 1'b0;
    s.typed_rsp = '0;
    host_requests.push_back(s);
  endtask

  // Mostly well-formed host sequences with random content, plus some raw noise.
  task automatic queue_random_traffic(input int count);
    int   added;
    int   pick;
    int   reads;
    req_t r;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      r    = random_req();
      if (pick < 25) begin
        // Keyboard offers a byte; the host usually picks it up.
        r.command        = CMD_TICK;
        r.kbd_byte_valid = 1'b1;
        r.irq_pending    = ($urandom_range(0, 3) == 0);
        queue_req(r);
        added++;
        if ($urandom_range(0, 2) != 0) begin
          r         = random_req();
          r.command = CMD_READ;
          r.port    = PORT_DATA;
          queue_req(r);
          added++;
        end
      end else if (pick < 40) begin
        // Staged write: arm a stage, then write the data port.
        r.command    = CMD_WRITE;
        r.port       = PORT_STATUS;
        r.write_data = CC_WRITE_OUTPUT + 8'($urandom_range(0, 3));
        queue_req(r);
        r         = random_req();
        r.command = CMD_WRITE;
        r.port    = PORT_DATA;
        queue_req(r);
        added += 2;
      end else if (pick < 55) begin
        r.command    = CMD_WRITE;
        r.port       = PORT_STATUS;
        r.write_data = random_ctrl_cmd();
        queue_req(r);
        added++;
      end else if (pick < 70) begin
        r.command = CMD_READ;
        r.port    = PORT_STATUS;
        queue_req(r);
        added++;
      end else if (pick < 80) begin
        // Speaker byte write or a burst of refresh toggle reads.
        if ($urandom_range(0, 2) == 0) begin
          r.command = CMD_WRITE;
          r.port    = PORT_SPEAKER;
          queue_req(r);
          added++;
        end else begin
          for (reads = $urandom_range(1, 8); reads > 0; reads--) begin
            r         = random_req();
            r.command = CMD_READ;
            r.port    = PORT_SPEAKER;
            queue_req(r);
            added++;
          end
        end
      end else if (pick < 85) begin
        r.command = CMD_READ;
        r.port    = PORT_TIMER;
        queue_req(r);
        added++;
      end else begin
        queue_req(r);
        added++;
      end
    end
  endtask

  // Sender: drives every queued request and records its expected response when accepted.
  task automatic send_host_requests();
    stim_t s;
    rsp_t  want;
    int    gap;
    while (host_requests.size() != 0) begin
      s   = host_requests.pop_front();
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (n_sent_reqs % 100 == 99) begin
        // Let the controller drain completely before the next request.
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_rsps.size() != 0) @(posedge clk);
      end else if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req_valid <= 1'b1;
      req_data  <= s.rq;
      do @(posedge clk); while (req_stall);
      predict_kbc_response(s.rq, want);
      expected_rsps.push_back(s.typed ? s.typed_rsp : want);
      n_sent_reqs++;
    end
    req_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Register write over the config port: setup cycle, then access until ready.
  task automatic write_config(input logic idx, input logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_KIND) begin
      cfg_kind = val[1:0];
    end else begin
      cfg_inport = val;
    end
  endtask

  // Receiver: random stall before each response, plus one long hold when asked.
  initial begin
    int stall_len;
    rsp_stall = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      stall_len = no_idle ? 0 : $urandom_range(0, 3);
      if (stall_len != 0) begin
        rsp_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endtask

  // Every accepted response is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("response 0x%0h arrived with nothing expected", rsp_data);
        n_fail++;
      end else begin
        chk_want = expected_rsps.pop_front();
        compare_field("read_data", chk_want.read_data, rsp_data.read_data);
        compare_field("kbd_byte_taken", 8'(chk_want.kbd_byte_taken),
                      8'(rsp_data.kbd_byte_taken));
        compare_field("irq_raise", 8'(chk_want.irq_raise), 8'(rsp_data.irq_raise));
        compare_field("kbd_send_valid", 8'(chk_want.kbd_send_valid),
                      8'(rsp_data.kbd_send_valid));
        compare_field("kbd_send_byte", chk_want.kbd_send_byte, rsp_data.kbd_send_byte);
        compare_field("speaker_update", 8'(chk_want.speaker_update),
                      8'(rsp_data.speaker_update));
        compare_field("speaker_bits", 8'(chk_want.speaker_bits), 8'(rsp_data.speaker_bits));
        compare_field("a20_update", 8'(chk_want.a20_update), 8'(rsp_data.a20_update));
        compare_field("a20_enable", 8'(chk_want.a20_enable), 8'(rsp_data.a20_enable));
        compare_field("cpu_reset_pulse", 8'(chk_want.cpu_reset_pulse),
                      8'(rsp_data.cpu_reset_pulse));
        n_checked++;
        n_taken  += int'(rsp_data.kbd_byte_taken);
        n_to_kbd += int'(rsp_data.kbd_send_valid);
        n_pulses += int'(rsp_data.cpu_reset_pulse);
      end
    end
  end

  // Main sequence: reset, directed table, then random phases under several settings.
  initial begin
    int         ph;
    logic [1:0] kind;
    logic [7:0] inport;
    rst       = 1'b1;
    req_valid = 1'b0;
    req_data  = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    no_idle   = 1'b0;
    long_hold = 1'b0;
    n_fail      = 0;
    n_sent_reqs = 0;
    n_checked   = 0;
    n_taken     = 0;
    n_to_kbd    = 0;
    n_pulses    = 0;
    n_settings  = 1;

    cfg_kind         = KIND_AT;
    cfg_inport       = INPUT_PORT_RESET;
    kb_data          = 8'h00;
    kb_outport       = 8'h00;
    kb_full          = 1'b0;
    kb_enabled       = 1'b0;
    kb_cmd_flag      = 1'b0;
    kb_stage         = STAGE_IDLE;
    kb_status_mode   = MODE_NORMAL;
    kb_speaker       = 8'h00;
    kb_refresh_count = TOGGLE_RESET;
    kb_refresh_bit   = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed table, run with the reset settings.
    host_requests.push_back(row(CMD_READ, PORT_STATUS, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
                                make_rsp(8'h14, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 2'b00,
                                         1'b0, 1'b0, 1'b0)));
    host_requests.push_back(row(CMD_WRITE, PORT_STATUS, CC_SELF_TEST, 1'b0, 8'h00, 1'b0, 1'b0,
                                1'b1, make_rsp(8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 2'b00,
                                               1'b0, 1'b0, 1'b0)));
    host_requests.push_back(row(CMD_READ, PORT_STATUS, 8'hff, 1'b1, 8'h77, 1'b0, 1'b0, 1'b1,
                                make_rsp(8'h17, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 2'b00,
                                         1'b0, 1'b0, 1'b0)));
    host_requests.push_back(row(CMD_READ, PORT_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
                                make_rsp(SELF_TEST_OK, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 2'b00,
                                         1'b0, 1'b0, 1'b0)));
    host_requests.push_back(row(CMD_WRITE, PORT_STATUS, CC_KBD_ENABLE, 1'b0, 8'h00, 1'b0, 1'b0,
                                1'b1, '0));
    host_requests.push_back(row(CMD_TICK, PORT_DATA, 8'h00, 1'b1, 8'hff, 1'b0, 1'b0, 1'b1,
                                make_rsp(8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 2'b00,
                                         1'b0, 1'b0, 1'b0)));
    host_requests.push_back(row(CMD_READ, PORT_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
                                make_rsp(8'hff, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 2'b00,
                                         1'b0, 1'b0, 1'b0)));
    host_requests.push_back(row(CMD_TICK, PORT_DATA, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 1'b1, '0));
    host_requests.push_back(row(CMD_READ, PORT_STATUS, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0, '0));
    host_requests.push_back(row(CMD_WRITE, PORT_STATUS, CC_WRITE_OUTPUT, 1'b0, 8'h00, 1'b0,
                                1'b0, 1'b0, '0));
    host_requests.push_back(row(CMD_WRITE, PORT_DATA, 8'hff, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
                                make_rsp(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 2'b00,
                                         1'b1, 1'b1, 1'b0)));
    host_requests.push_back(row(CMD_WRITE, PORT_STATUS, CC_READ_OUTPUT, 1'b0, 8'h00, 1'b0, 1'b0,
                                1'b0, '0));
    host_requests.push_back(row(CMD_WRITE, PORT_STATUS, CC_WRITE_KBD_BUF, 1'b0, 8'h00, 1'b0,
                                1'b0, 1'b0, '0));
    host_requests.push_back(row(CMD_WRITE, PORT_DATA, 8'h00, 1'b1, 8'hff, 1'b0, 1'b1, 1'b0, '0));
    host_requests.push_back(row(CMD_WRITE, PORT_DATA, 8'ha5, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    host_requests.push_back(row(CMD_WRITE, PORT_STATUS, CC_WRITE_AUX_BUF, 1'b0, 8'h00, 1'b0,
                                1'b0, 1'b0, '0));
    host_requests.push_back(row(CMD_WRITE, PORT_DATA, 8'h12, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    host_requests.push_back(row(CMD_WRITE, PORT_STATUS, CC_WRITE_AUX, 1'b0, 8'h00, 1'b0, 1'b0,
                                1'b0, '0));
    host_requests.push_back(row(CMD_WRITE, PORT_DATA, 8'h34, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    host_requests.push_back(row(CMD_WRITE, PORT_STATUS, CC_STATUS_LOW, 1'b0, 8'h00, 1'b0, 1'b0,
                                1'b0, '0));
    host_requests.push_back(row(CMD_READ, PORT_STATUS, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    host_requests.push_back(row(CMD_WRITE, PORT_STATUS, CC_STATUS_HIGH, 1'b0, 8'h00, 1'b0, 1'b0,
                                1'b0, '0));
    host_requests.push_back(row(CMD_READ, PORT_STATUS, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    host_requests.push_back(row(CMD_WRITE, PORT_STATUS, CC_READ_INPUT, 1'b0, 8'h00, 1'b1, 1'b0,
                                1'b0, '0));
    host_requests.push_back(row(CMD_WRITE, PORT_SPEAKER, 8'hff, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
                                make_rsp(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 2'b11,
                                         1'b0, 1'b0, 1'b0)));
    host_requests.push_back(row(CMD_READ, PORT_SPEAKER, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    host_requests.push_back(row(CMD_READ, PORT_TIMER, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1,
                                make_rsp(8'h20, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 2'b00,
                                         1'b0, 1'b0, 1'b0)));
    host_requests.push_back(row(CMD_WRITE, PORT_STATUS, {CC_PULSE_HIGH, 4'he}, 1'b0, 8'h00, 1'b0,
                                1'b0, 1'b1, make_rsp(8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0,
                                                     2'b00, 1'b1, 1'b1, 1'b1)));
    host_requests.push_back(row(CMD_WRITE, PORT_STATUS, CC_KBD_DISABLE, 1'b0, 8'h00, 1'b0, 1'b0,
                                1'b0, '0));
    host_requests.push_back(row(CMD_SPARE, PORT_STATUS, 8'hff, 1'b1, 8'hff, 1'b0, 1'b1, 1'b1,
                                '0));
    host_requests.push_back(row(CMD_READ, PORT_SPARE, 8'hff, 1'b1, 8'hff, 1'b0, 1'b1, 1'b1, '0));
    send_host_requests();

    // Random phases; the fourth holds the receiver off while requests keep coming.
    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       begin kind = KIND_AT386; inport = 8'h00; end
        1:       begin kind = KIND_PS2;   inport = 8'hff; end
        2:       begin kind = KIND_SPARE; inport = 8'($urandom_range(0, 255)); end
        3:       begin kind = KIND_AT;    inport = 8'($urandom_range(0, 255)); end
        4:       begin kind = KIND_PS2;   inport = 8'h0f; end
        5:       begin kind = KIND_AT386; inport = 8'hf0; end
        default: begin
          kind   = 2'($urandom_range(0, 3));
          inport = 8'($urandom_range(0, 255));
        end
      endcase
      write_config(REG_KIND, {6'b0, kind});
      write_config(REG_INPUT_PORT, inport);
      n_settings++;
      no_idle   = (ph == 3) || (ph == 5);
      long_hold = (ph == 3);
      queue_random_traffic(PHASE_ITEMS);
      send_host_requests();
    end
    wait_drained();

    $display("Sent %0d requests under %0d controller settings; %0d responses checked.",
             n_sent_reqs, n_settings, n_checked);
    $display("Keyboard bytes taken: %0d, bytes sent to keyboard: %0d, reset pulses: %0d.",
             n_taken, n_to_kbd, n_pulses);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/kbc8042_pkg.sv
design/kbc8042_engine.sv
design/keyboard_controller_8042.sv
tb/keyboard_controller_8042_tb.sv
